// ===== design/greedy_column_rank_balancer_assert.svh =====
// ----------------------------------------------------------------------------
// greedy_column_rank_balancer_assert.svh
// Assertion macros shared by the balancer RTL.
// ----------------------------------------------------------------------------
`ifndef GREEDY_COLUMN_RANK_BALANCER_ASSERT_SVH
`define GREEDY_COLUMN_RANK_BALANCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define GCRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gcrb check failed");

// Next-cycle implication, disabled while reset is low.
`define GCRB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gcrb check failed");

`endif

// ===== design/gcrb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcrb_pkg
// Shared types and fixed field widths of the column rank balancer.
// ----------------------------------------------------------------------------
package gcrb_pkg;

    localparam int ElemW    = 32;
    localparam int ColW     = 21;
    localparam int RankOutW = 6;
    localparam int SizeW    = 13;
    localparam int CfgW     = 7;
    localparam int SDataW   = 24;
    localparam int SUserW   = 2;
    localparam int MDataW   = 64;
    localparam int MPadW    = MDataW - (RankOutW + ColW + ElemW);

    localparam logic [ColW-1:0] ColTotalMax = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_UPDATE
    } state_t;

    // per-rank totals as held in the table
    typedef struct packed {
        logic [ElemW-1:0] elem;
        logic [ColW-1:0]  col;
    } totals_t;

    // sequencer to compare unit
    typedef struct packed {
        logic start;
        logic cmp_en;
    } scan_ctl_t;

endpackage

// ===== design/gcrb_total_mem.sv =====
// ----------------------------------------------------------------------------
// gcrb_total_mem
// Per-rank totals table: one write port, one registered read port, and
// valid bits so that clear needs no pass over the entries.
// ----------------------------------------------------------------------------
module gcrb_total_mem #(
    parameter int RANKS_MAX = 64,
    localparam int IW = (RANKS_MAX > 1) ? $clog2(RANKS_MAX) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              rd_en,
    input  logic [IW-1:0]     rd_addr,
    output gcrb_pkg::totals_t rd_data,
    input  logic              wr_en,
    input  logic [IW-1:0]     wr_addr,
    input  gcrb_pkg::totals_t wr_data
);

    gcrb_pkg::totals_t      total_mem [RANKS_MAX];
    gcrb_pkg::totals_t      rd_raw_reg;
    logic                   rd_hit_reg;
    logic [RANKS_MAX-1:0]   valid_reg;
    logic [RANKS_MAX-1:0]   valid_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            total_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_raw_reg <= total_mem[rd_addr];
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_hit_reg ? rd_raw_reg : '0;

    always_comb begin
        valid_next = valid_reg;
        if (clr) begin
            valid_next = '0;
        end
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== design/gcrb_scan_unit.sv =====
// ----------------------------------------------------------------------------
// gcrb_scan_unit
// Shared compare unit: keeps the least element total seen in a scan.
// ----------------------------------------------------------------------------
module gcrb_scan_unit #(
    parameter int RANKS_MAX = 64,
    localparam int IW = (RANKS_MAX > 1) ? $clog2(RANKS_MAX) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gcrb_pkg::scan_ctl_t        ctl,
    input  logic [IW-1:0]              cmp_idx,
    input  logic [gcrb_pkg::ElemW-1:0] cmp_val,
    output logic [IW-1:0]              best_idx
);

    logic                       found_reg;
    logic [IW-1:0]              best_idx_reg;
    logic [gcrb_pkg::ElemW-1:0] best_val_reg;
    logic                       take;

    // strict less-than over ascending ranks keeps the lowest on a tie
    assign take     = ctl.cmp_en && (!found_reg || (cmp_val < best_val_reg));
    assign best_idx = best_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg <= cmp_idx;
            best_val_reg <= cmp_val;
        end
    end

endmodule

// ===== design/greedy_column_rank_balancer.sv =====
// ----------------------------------------------------------------------------
// greedy_column_rank_balancer
// Greedy least-loaded assignment of work columns to ranks.
//
// Each input word is one column with its element count. A forced column goes
// to the rank it carries; any other column goes to the rank with the least
// element total among the ranks still open in the current round (lowest rank
// wins a tie), and that rank then leaves the round. An empty round refills
// with every configured rank. One result word per input word reports the
// rank and its column and element totals after the update; a forced rank at
// or above the rank count is flagged in m_tuser and writes no totals. A greedy
// column scans the n effective ranks through the single read port of the
// totals table, one rank per cycle to the shared comparator; a forced column
// skips the scan, and a bad forced rank skips the table read as well.
// One column is in flight at a time. A finished result sits in the output
// register, so the next column is accepted while it waits. Totals clear on
// reset or new_set via valid bits, with no clearing pass. num_ranks of 0 acts
// as 1, above RANKS_MAX as RANKS_MAX; write it only while the block is idle.
// ----------------------------------------------------------------------------
module greedy_column_rank_balancer #(
    parameter int RANKS_MAX = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration: num_ranks
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gcrb_pkg::CfgW-1:0]    cfg_data,
    // input columns
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gcrb_pkg::SDataW-1:0]  s_tdata,  // [5:0] forced_rank, [18:6] column_size
    input  logic [gcrb_pkg::SUserW-1:0]  s_tuser,  // [0] new_set, [1] forced
    // results
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gcrb_pkg::MDataW-1:0]  m_tdata,  // [5:0] assigned_rank,
                                                   // [26:6] rank_column_total,
                                                   // [58:27] rank_element_total
    output logic                         m_tuser   // bad_rank
);

`include "greedy_column_rank_balancer_assert.svh"

    localparam int IW = (RANKS_MAX > 1) ? $clog2(RANKS_MAX) : 1;
    localparam int CW = $clog2(RANKS_MAX + 1);
    localparam int NW = (CW > gcrb_pkg::CfgW) ? CW : gcrb_pkg::CfgW;
    localparam int XW = (IW > gcrb_pkg::RankOutW) ? IW : gcrb_pkg::RankOutW;

    // ---------------- input field split ----------------
    logic                          in_new_set;
    logic                          in_forced;
    logic [gcrb_pkg::RankOutW-1:0] in_frank;
    logic [gcrb_pkg::SizeW-1:0]    in_size;

    assign in_new_set = s_tuser[0];
    assign in_forced  = s_tuser[1];
    assign in_frank   = s_tdata[5:0];
    assign in_size    = s_tdata[18:6];

    // ---------------- registers ----------------
    gcrb_pkg::state_t              state_reg, state_next;
    logic [gcrb_pkg::CfgW-1:0]     num_ranks_reg;
    logic [RANKS_MAX-1:0]          round_reg, round_next;
    logic [RANKS_MAX-1:0]          elig_reg, elig_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          pend_reg, pend_next;
    logic [IW-1:0]                 pend_idx_reg, pend_idx_next;
    logic [IW-1:0]                 rank_reg, rank_next;
    logic                          forced_reg, forced_next;
    logic                          bad_reg, bad_next;
    logic [gcrb_pkg::RankOutW-1:0] frank_reg, frank_next;
    logic [gcrb_pkg::SizeW-1:0]    size_reg, size_next;
    logic                          out_valid_reg, out_valid_next;
    logic [gcrb_pkg::MDataW-1:0]   out_data_reg, out_data_next;
    logic                          out_bad_reg, out_bad_next;

    // ---------------- shared signals ----------------
    logic                          accept;
    logic                          out_free;
    logic [CW-1:0]                 n_eff;
    logic [NW-1:0]                 num_x;
    logic [RANKS_MAX-1:0]          rank_mask;
    logic [RANKS_MAX-1:0]          round_after;
    logic [RANKS_MAX-1:0]          avail;
    logic                          refill;
    logic                          bad_in;
    logic                          last_issue;

    logic                          clr;
    logic                          rd_en;
    logic [IW-1:0]                 rd_addr;
    gcrb_pkg::totals_t             rd_data;
    logic                          wr_en;
    gcrb_pkg::totals_t             wr_data;
    gcrb_pkg::scan_ctl_t           scan_ctl;
    logic [IW-1:0]                 best_idx;
    logic [IW-1:0]                 sel_rank;
    logic [gcrb_pkg::ElemW:0]      sum_wide;
    logic [gcrb_pkg::ElemW-1:0]    new_elem;
    logic [gcrb_pkg::ColW-1:0]     new_col;
    logic [XW-1:0]                 rank_x;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == gcrb_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

    // effective rank count, clamped to 1..RANKS_MAX
    always_comb begin
        num_x = NW'(num_ranks_reg);
        if (num_x == '0) begin
            n_eff = CW'(1);
        end else if (num_x > NW'(RANKS_MAX)) begin
            n_eff = CW'(RANKS_MAX);
        end else begin
            n_eff = CW'(num_x);
        end
    end

    always_comb begin
        for (int i = 0; i < RANKS_MAX; i++) begin
            rank_mask[i] = (i < int'(n_eff));
        end
    end

    // round as seen by an incoming column, after an optional new_set
    assign round_after = in_new_set ? '0 : round_reg;
    assign avail       = round_after & rank_mask;
    assign refill      = (avail == '0);
    assign bad_in      = !(NW'(in_frank) < NW'(n_eff));
    assign last_issue  = (cnt_reg == (n_eff - CW'(1)));
    assign sel_rank    = forced_reg ? rank_reg : best_idx;

    // saturating updates of the fetched totals
    assign sum_wide = {1'b0, rd_data.elem} + (gcrb_pkg::ElemW + 1)'(size_reg);
    assign new_elem = sum_wide[gcrb_pkg::ElemW] ? '1 : sum_wide[gcrb_pkg::ElemW-1:0];
    assign new_col  = (rd_data.col == gcrb_pkg::ColTotalMax) ? rd_data.col
                                                               : rd_data.col + 1'b1;
    assign rank_x   = XW'(rank_reg);
    assign wr_data  = '{elem: new_elem, col: new_col};

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gcrb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!in_forced) begin
                        state_next = gcrb_pkg::ST_SCAN;
                    end else if (bad_in) begin
                        state_next = gcrb_pkg::ST_UPDATE;
                    end else begin
                        state_next = gcrb_pkg::ST_FETCH;
                    end
                end
            end
            gcrb_pkg::ST_SCAN: begin
                if (last_issue) begin
                    state_next = gcrb_pkg::ST_DRAIN;
                end
            end
            gcrb_pkg::ST_DRAIN:  state_next = gcrb_pkg::ST_FETCH;
            gcrb_pkg::ST_FETCH:  state_next = gcrb_pkg::ST_UPDATE;
            gcrb_pkg::ST_UPDATE: begin
                if (out_free) begin
                    state_next = gcrb_pkg::ST_IDLE;
                end
            end
            default: state_next = gcrb_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath control ----------------
    always_comb begin
        round_next     = round_reg;
        elig_next      = elig_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        rank_next      = rank_reg;
        forced_next    = forced_reg;
        bad_next       = bad_reg;
        frank_next     = frank_reg;
        size_next      = size_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_bad_next   = out_bad_reg;
        clr            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[IW-1:0];
        wr_en          = 1'b0;
        scan_ctl.start = 1'b0;
        // the compare happens in the cycle after the read
        scan_ctl.cmp_en = pend_reg && elig_reg[pend_idx_reg];

        unique case (state_reg)
            gcrb_pkg::ST_IDLE: begin
                if (accept) begin
                    clr         = in_new_set;
                    round_next  = round_after;
                    frank_next  = in_frank;
                    size_next   = in_size;
                    forced_next = in_forced;
                    bad_next    = in_forced && bad_in;
                    rank_next   = IW'(in_frank);
                    if (!in_forced) begin
                        scan_ctl.start = 1'b1;
                        cnt_next       = '0;
                        elig_next      = refill ? rank_mask : avail;
                        if (refill) begin
                            round_next = round_after | rank_mask;
                        end
                    end
                end
            end
            gcrb_pkg::ST_SCAN: begin
                rd_en         = 1'b1;
                rd_addr       = cnt_reg[IW-1:0];
                pend_next     = 1'b1;
                pend_idx_next = cnt_reg[IW-1:0];
                cnt_next      = cnt_reg + CW'(1);
            end
            gcrb_pkg::ST_DRAIN: begin
            end
            gcrb_pkg::ST_FETCH: begin
                rank_next = sel_rank;
                rd_en     = 1'b1;
                rd_addr   = sel_rank;
                if (!forced_reg) begin
                    round_next[sel_rank] = 1'b0;
                end
            end
            gcrb_pkg::ST_UPDATE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_bad_next   = bad_reg;
                    if (bad_reg) begin
                        out_data_next = {{(gcrb_pkg::MDataW - gcrb_pkg::RankOutW){1'b0}},
                                         frank_reg};
                    end else begin
                        wr_en         = 1'b1;
                        out_data_next = {{gcrb_pkg::MPadW{1'b0}}, new_elem, new_col,
                                         rank_x[gcrb_pkg::RankOutW-1:0]};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gcrb_pkg::ST_IDLE;
            num_ranks_reg <= gcrb_pkg::CfgW'(1);
            round_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                num_ranks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        elig_reg     <= elig_next;
        cnt_reg      <= cnt_next;
        pend_idx_reg <= pend_idx_next;
        rank_reg     <= rank_next;
        forced_reg   <= forced_next;
        bad_reg      <= bad_next;
        frank_reg    <= frank_next;
        size_reg     <= size_next;
        out_data_reg <= out_data_next;
        out_bad_reg  <= out_bad_next;
    end

    // ---------------- units ----------------
    gcrb_total_mem #(
        .RANKS_MAX (RANKS_MAX)
    ) u_total_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (clr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (rank_reg),
        .wr_data (wr_data)
    );

    gcrb_scan_unit #(
        .RANKS_MAX (RANKS_MAX)
    ) u_scan_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (scan_ctl),
        .cmp_idx  (pend_idx_reg),
        .cmp_val  (rd_data.elem),
        .best_idx (best_idx)
    );

    // ---------------- checks ----------------
    // one column in flight: an accepted column always closes the input
    `GCRB_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, accept, !s_tready)
    // the scan never reads past the configured ranks
    `GCRB_ASSERT_IMP(a_scan_bound, aclk, aresetn, state_reg == gcrb_pkg::ST_SCAN, cnt_reg < n_eff)
    // totals are only written for a rank in range
    `GCRB_ASSERT_IMP(a_write_in_range, aclk, aresetn, wr_en, int'(rank_reg) < int'(n_eff))
    // a flagged result carries no totals
    `GCRB_ASSERT_IMP(a_bad_no_totals, aclk, aresetn, out_valid_reg && out_bad_reg, out_data_reg[58:6] == '0)
    // a greedy pick leaves the round
    `GCRB_ASSERT_NEXT(a_pick_leaves_round, aclk, aresetn, state_reg == gcrb_pkg::ST_FETCH && !forced_reg, !round_reg[rank_reg])

endmodule
